[src/hrtp_pkg.sv]
// shared types, constants and scaling functions of the heater ramp drive stage
package hrtp_pkg;

   localparam logic [6:0]  PCT_FULL   = 7'd100;
   // ceil(100 * 2^24 / 255), exact floor(x*100/255) for any 8-bit command
   localparam logic [22:0] PCT_RECIP  = 23'd6579301;
   // 255 * ceil(2^24 / 100), exact floor(p*255/100) for p up to 100
   localparam logic [25:0] DUTY_RECIP = 26'd42782115;

   localparam logic [1:0]  CSR_PWM_CAPABLE = 2'd0;
   localparam logic [1:0]  CSR_CYCLE_TIME  = 2'd1;
   localparam logic [1:0]  CSR_MAX_STEP    = 2'd2;

   localparam logic [15:0] CYCLE_TIME_RESET = 16'd10000;
   localparam logic [6:0]  MAX_STEP_RESET   = 7'd5;

   typedef enum logic {
      OP_RAMP   = 1'b0,
      OP_MANUAL = 1'b1
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [6:0]  target;
      logic        manual_on;
      logic [6:0]  manual_percent;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       relay_on;
      logic       heater_on;
      logic [6:0] applied_percent;
   } result_type;

   typedef struct packed {
      logic        pwm_capable;
      logic [15:0] cycle_time_ms;
      logic [6:0]  max_step;
   } cfg_type;

   typedef struct packed {
      logic [6:0]  last_percent;
      logic [31:0] window_start;
   } ramp_state_type;

   function automatic logic [6:0] cmd_to_pct(input logic [7:0] cmd);
      logic [30:0] prod;
      begin
         prod = 31'(cmd) * 31'(PCT_RECIP);
         return prod[30:24];
      end
   endfunction

   function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
      logic [31:0] prod;
      begin
         prod = 32'(pct) * 32'(DUTY_RECIP);
         return prod[31:24];
      end
   endfunction

endpackage

[src/heater_ramp_time_proportioning_core.sv]
// top level of the heater ramp and time-proportioning drive stage
// Takes one request per clock cycle unless the response side stalls, and returns
// one response per request: the command is scaled to a percent into the input
// register, then the ramp limit, the PWM duty or relay decision and the state
// update happen in a single pass into the response register. The ramp state
// (last percent and window start) is updated in that pass, so consecutive
// requests see each other's effect with no extra wait. Configuration writes
// are always accepted and take effect on the next request.
module heater_ramp_time_proportioning_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // pid_value, manual_on, manual_percent, now_ms
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // pwm_duty, relay_on, heater_on, applied_percent, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   hrtp_pkg::item_type       in_ff,    in_in;
   logic                     in_valid_ff, in_valid_in;
   hrtp_pkg::result_type     out_ff,   out_in;
   logic                     out_valid_ff, out_valid_in;
   hrtp_pkg::cfg_type        cfg_ff,   cfg_in;
   hrtp_pkg::ramp_state_type state_ff, state_in;
   hrtp_pkg::result_type     calc_result;
   hrtp_pkg::ramp_state_type calc_state;
   logic                     advance;
   logic                     req_accept;

   hrtp_calc u_calc (
      .item       (in_ff),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .result     (calc_result),
      .state_next (calc_state)
   );

   always_comb begin
      advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_accept = req_tvalid && req_tready;
      csr_ready  = 1'b1;

      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_in.opcode         = hrtp_pkg::op_type'(req_tuser);
         in_in.target         = hrtp_pkg::cmd_to_pct(req_tdata[7:0]);
         in_in.manual_on      = req_tdata[8];
         in_in.manual_percent = req_tdata[15:9];
         in_in.now_ms         = req_tdata[47:16];
         in_valid_in          = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         out_in       = calc_result;
         out_valid_in = 1'b1;
         state_in     = calc_state;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hrtp_pkg::CSR_PWM_CAPABLE: cfg_in.pwm_capable   = csr_data[0];
            hrtp_pkg::CSR_CYCLE_TIME:  cfg_in.cycle_time_ms = csr_data;
            hrtp_pkg::CSR_MAX_STEP:    cfg_in.max_step      = csr_data[6:0];
            default:                   cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         cfg_ff.pwm_capable   <= 1'b0;
         cfg_ff.cycle_time_ms <= hrtp_pkg::CYCLE_TIME_RESET;
         cfg_ff.max_step      <= hrtp_pkg::MAX_STEP_RESET;
         state_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.applied_percent, out_ff.heater_on,
                        out_ff.relay_on, out_ff.pwm_duty};

   // ramp state never leaves the percent range
   assert property (@(posedge clock) disable iff (reset)
      state_ff.last_percent <= hrtp_pkg::PCT_FULL)
      else $error("ramp percent out of range");

   // a response never drives both the relay and a pwm duty
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.relay_on && (out_ff.pwm_duty != 8'd0)))
      else $error("relay and pwm driven together");

   // heater status follows the drive that was chosen
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.heater_on == (out_ff.relay_on || (out_ff.pwm_duty != 8'd0))))
      else $error("heater status inconsistent with drive");

   // ramp state only moves when a request is processed
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("ramp state changed without a request");

   // the applied percent stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.applied_percent <= hrtp_pkg::PCT_FULL))
      else $error("applied percent out of range");

endmodule

[src/hrtp_calc.sv]
// ramp limiter, duty scaling and time-proportioning decision for one request
module hrtp_calc (
   input  hrtp_pkg::item_type       item,
   input  hrtp_pkg::cfg_type        cfg,
   input  hrtp_pkg::ramp_state_type state_cur,
   output hrtp_pkg::result_type     result,
   output hrtp_pkg::ramp_state_type state_next
);

   logic [6:0]  step_diff;
   logic [6:0]  ramp_pct;
   logic [6:0]  man_pct;
   logic [6:0]  man_applied;
   logic [7:0]  man_duty;
   logic [7:0]  ramp_duty;
   logic [31:0] elapsed;
   logic        restart;
   logic [15:0] elapsed_win;
   logic [22:0] lhs;
   logic [22:0] rhs;
   logic        ramp_relay;

   always_comb begin
      if (item.target >= state_cur.last_percent) begin
         step_diff = item.target - state_cur.last_percent;
         ramp_pct  = (step_diff > cfg.max_step) ?
                     state_cur.last_percent + cfg.max_step : item.target;
      end else begin
         step_diff = state_cur.last_percent - item.target;
         ramp_pct  = (step_diff > cfg.max_step) ?
                     state_cur.last_percent - cfg.max_step : item.target;
      end

      man_pct     = (item.manual_percent > hrtp_pkg::PCT_FULL) ?
                    hrtp_pkg::PCT_FULL : item.manual_percent;
      man_applied = item.manual_on ? man_pct : 7'd0;
      man_duty    = hrtp_pkg::pct_to_duty(man_applied);
      ramp_duty   = hrtp_pkg::pct_to_duty(ramp_pct);

      // window restart and exact on-time compare
      elapsed     = item.now_ms - state_cur.window_start;
      restart     = elapsed >= {16'd0, cfg.cycle_time_ms};
      elapsed_win = restart ? 16'd0 : elapsed[15:0];
      lhs         = 23'(elapsed_win) * 23'(hrtp_pkg::PCT_FULL);
      rhs         = 23'(cfg.cycle_time_ms) * 23'(ramp_pct);
      ramp_relay  = lhs < rhs;

      result     = '0;
      state_next = state_cur;
      case (item.opcode)
         hrtp_pkg::OP_MANUAL: begin
            if (cfg.pwm_capable) begin
               result.pwm_duty        = man_duty;
               result.heater_on       = man_duty != 8'd0;
               result.applied_percent = man_applied;
            end else begin
               result.relay_on        = item.manual_on;
               result.heater_on       = item.manual_on;
               result.applied_percent = item.manual_on ? hrtp_pkg::PCT_FULL : 7'd0;
            end
         end
         hrtp_pkg::OP_RAMP: begin
            if (cfg.pwm_capable) begin
               result.pwm_duty  = ramp_duty;
               result.heater_on = ramp_duty != 8'd0;
            end else begin
               result.relay_on  = ramp_relay;
               result.heater_on = ramp_relay;
               if (restart) begin
                  state_next.window_start = item.now_ms;
               end
            end
            result.applied_percent  = ramp_pct;
            state_next.last_percent = ramp_pct;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule
